// ===== rtl/blid_pkg.sv =====
// Package for the bounded list block: list depth, derived widths, operation,
// status and sequencer state codes. No dependencies.
`default_nettype none

package blid_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int OCC_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int KIND_W  = 3;
  localparam int POS_W   = 10;
  localparam int STAT_W  = 2;
  localparam int ENT_W   = 11;

  typedef enum logic [KIND_W-1:0] {
    K_INS_FRONT = 3'd0,
    K_DEL_FRONT = 3'd1,
    K_DEL_END   = 3'd2,
    K_DEL_POS   = 3'd3,
    K_READ_POS  = 3'd4
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS,
    S_INS_END,
    S_INS_FIN,
    S_DEL,
    S_DEL_END,
    S_RD,
    S_RD_END,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/blid_in_if.sv =====
// Input channel of the bounded list block: valid/ready handshake and one
// operation item. Depends on blid_pkg for field widths.
`default_nettype none

interface blid_in_if;
  logic                               valid;
  logic                               ready;
  logic [blid_pkg::KIND_W-1:0]        kind;
  logic signed [blid_pkg::DATA_W-1:0] value;
  logic [blid_pkg::POS_W-1:0]         position;

  modport source (output valid, kind, value, position, input ready);
  modport sink   (input valid, kind, value, position, output ready);
endinterface

`default_nettype wire

// ===== rtl/blid_out_if.sv =====
// Result channel of the bounded list block: valid/ready handshake and one
// result item. Depends on blid_pkg for field widths.
`default_nettype none

interface blid_out_if;
  logic                               valid;
  logic                               ready;
  logic [blid_pkg::STAT_W-1:0]        status;
  logic signed [blid_pkg::DATA_W-1:0] data_out;
  logic [blid_pkg::ENT_W-1:0]         entries;

  modport source (output valid, status, data_out, entries, input ready);
  modport sink   (input valid, status, data_out, entries, output ready);
endinterface

`default_nettype wire

// ===== rtl/bounded_list_insert_delete_top.sv =====
// Bounded ordered list top level: entry memory, shift sequencer, output register.
// Depends on blid_pkg, blid_in_if and blid_out_if.
//
// Holds up to DEPTH signed 32-bit entries with the front entry in slot 0 of a
// single-port-write, registered-read memory. One item is in work at a time;
// in_ch.ready is high only while the sequencer is idle. Every entry that moves
// passes once through the memory read port and once through its write port,
// overlapped, so the memory port pair sets the cost: an insert at the front
// moves every held entry one slot back (none in an empty list), a delete moves
// the entries after the deleted one one slot forward, and a read or a rejected
// item (empty, full, out of range, unknown kind) moves none. The result sits in
// an output register, so the sequencer takes and works the next item while a
// result waits to be taken, holding its own result until the register is free.
`default_nettype none

module bounded_list_insert_delete_top (
  input  wire        clk,
  input  wire        rst_n,
  blid_in_if.sink    in_ch,
  blid_out_if.source out_ch
);

  localparam int IW = blid_pkg::IDX_W;
  localparam int OW = blid_pkg::OCC_W;
  localparam int DW = blid_pkg::DATA_W;

  blid_pkg::state_t  state_r, state_nxt;
  logic [OW-1:0]     occ_r, occ_nxt;
  logic [IW-1:0]     cur_r, cur_nxt;
  logic [IW-1:0]     end_r, end_nxt;
  logic [IW-1:0]     start_r, start_nxt;
  logic              pend_r, pend_nxt;
  logic [IW-1:0]     pend_src_r, pend_src_nxt;
  logic [DW-1:0]     val_r, val_nxt;
  blid_pkg::status_t res_status_r, res_status_nxt;
  logic [DW-1:0]     res_data_r, res_data_nxt;
  logic              out_valid_r, out_valid_nxt;
  blid_pkg::status_t out_status_r, out_status_nxt;
  logic [DW-1:0]     out_data_r, out_data_nxt;
  logic [OW-1:0]     out_occ_r, out_occ_nxt;

  logic [DW-1:0]     mem [blid_pkg::DEPTH];
  logic [DW-1:0]     rd_data_r;
  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic [DW-1:0]     wr_data;

  logic              occ_full;
  logic              occ_zero;
  logic              pos_bad;
  logic [IW-1:0]     occ_last;
  logic [IW-1:0]     pos_idx;

  assign occ_full = (occ_r == OW'(blid_pkg::DEPTH));
  assign occ_zero = (occ_r == '0);
  assign occ_last = IW'(occ_r - OW'(1));
  assign pos_idx  = IW'(in_ch.position - blid_pkg::POS_W'(1));
  assign pos_bad  = (in_ch.position == '0) ||
                    ({1'b0, in_ch.position} > blid_pkg::ENT_W'(occ_r));

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    occ_nxt        = occ_r;
    cur_nxt        = cur_r;
    end_nxt        = end_r;
    start_nxt      = start_r;
    pend_nxt       = pend_r;
    pend_src_nxt   = pend_src_r;
    val_nxt        = val_r;
    res_status_nxt = res_status_r;
    res_data_nxt   = res_data_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_occ_nxt    = out_occ_r;
    rd_en          = 1'b0;
    rd_addr        = cur_r;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = rd_data_r;
    in_ch.ready    = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      blid_pkg::S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          val_nxt        = in_ch.value;
          res_status_nxt = blid_pkg::ST_OK;
          res_data_nxt   = '0;
          pend_nxt       = 1'b0;
          end_nxt        = occ_last;
          state_nxt      = blid_pkg::S_DONE;
          case (in_ch.kind)
            blid_pkg::K_INS_FRONT: begin
              if (occ_full) begin
                res_status_nxt = blid_pkg::ST_FULL;
              end else if (occ_zero) begin
                wr_en   = 1'b1;
                wr_data = in_ch.value;
                occ_nxt = OW'(1);
              end else begin
                cur_nxt   = occ_last;
                state_nxt = blid_pkg::S_INS;
              end
            end
            blid_pkg::K_DEL_FRONT, blid_pkg::K_DEL_END: begin
              if (occ_zero) begin
                res_status_nxt = blid_pkg::ST_EMPTY;
              end else begin
                cur_nxt   = (in_ch.kind == blid_pkg::K_DEL_FRONT) ? '0 : occ_last;
                start_nxt = (in_ch.kind == blid_pkg::K_DEL_FRONT) ? '0 : occ_last;
                state_nxt = blid_pkg::S_DEL;
              end
            end
            blid_pkg::K_DEL_POS, blid_pkg::K_READ_POS: begin
              if (occ_zero) begin
                res_status_nxt = blid_pkg::ST_EMPTY;
              end else if (pos_bad) begin
                res_status_nxt = blid_pkg::ST_RANGE;
              end else begin
                cur_nxt   = pos_idx;
                start_nxt = pos_idx;
                state_nxt = (in_ch.kind == blid_pkg::K_DEL_POS) ?
                            blid_pkg::S_DEL : blid_pkg::S_RD;
              end
            end
            default: begin
              res_status_nxt = blid_pkg::ST_RANGE;
            end
          endcase
        end
      end

      // move entries one slot toward the back, last entry first
      blid_pkg::S_INS: begin
        rd_en = 1'b1;
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = pend_src_r + IW'(1);
        end
        pend_nxt     = 1'b1;
        pend_src_nxt = cur_r;
        if (cur_r == '0) begin
          state_nxt = blid_pkg::S_INS_END;
        end else begin
          cur_nxt = cur_r - IW'(1);
        end
      end

      blid_pkg::S_INS_END: begin
        wr_en     = 1'b1;
        wr_addr   = pend_src_r + IW'(1);
        state_nxt = blid_pkg::S_INS_FIN;
      end

      blid_pkg::S_INS_FIN: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data   = val_r;
        occ_nxt   = occ_r + OW'(1);
        state_nxt = blid_pkg::S_DONE;
      end

      // capture the deleted entry, then move later entries toward the front
      blid_pkg::S_DEL: begin
        rd_en = 1'b1;
        if (pend_r) begin
          if (pend_src_r == start_r) begin
            res_data_nxt = rd_data_r;
          end else begin
            wr_en   = 1'b1;
            wr_addr = pend_src_r - IW'(1);
          end
        end
        pend_nxt     = 1'b1;
        pend_src_nxt = cur_r;
        if (cur_r == end_r) begin
          state_nxt = blid_pkg::S_DEL_END;
        end else begin
          cur_nxt = cur_r + IW'(1);
        end
      end

      blid_pkg::S_DEL_END: begin
        if (pend_src_r == start_r) begin
          res_data_nxt = rd_data_r;
        end else begin
          wr_en   = 1'b1;
          wr_addr = pend_src_r - IW'(1);
        end
        occ_nxt   = occ_r - OW'(1);
        state_nxt = blid_pkg::S_DONE;
      end

      blid_pkg::S_RD: begin
        rd_en     = 1'b1;
        state_nxt = blid_pkg::S_RD_END;
      end

      blid_pkg::S_RD_END: begin
        res_data_nxt = rd_data_r;
        state_nxt    = blid_pkg::S_DONE;
      end

      blid_pkg::S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_data_nxt   = res_data_r;
          out_occ_nxt    = occ_r;
          state_nxt      = blid_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = blid_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= blid_pkg::S_IDLE;
      occ_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    end_r        <= end_nxt;
    start_r      <= start_nxt;
    pend_src_r   <= pend_src_nxt;
    val_r        <= val_nxt;
    res_status_r <= res_status_nxt;
    res_data_r   <= res_data_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.data_out = out_data_r;
  assign out_ch.entries  = blid_pkg::ENT_W'(out_occ_r);

`ifndef ASSERT_OFF
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OW'(blid_pkg::DEPTH))
    else $error("entry count above depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("item accepted while previous item in work");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> OW'(wr_addr) <= occ_r)
    else $error("write beyond held entries");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == blid_pkg::ST_FULL |->
      out_occ_r == OW'(blid_pkg::DEPTH))
    else $error("full status with list not full");

  a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != blid_pkg::ST_OK |-> out_data_r == '0)
    else $error("nonzero data on rejected item");
`endif

endmodule

`default_nettype wire
